[hw/rtl/chs_pkg.sv]
// shared types and constants of the chained hash set
package chs_pkg;

    // defaults of the top-level parameters
    localparam int BUCKETS_DEF    = 7;
    localparam int POOL_NODES_DEF = 64;
    localparam int VALUE_BITS_DEF = 10;

    // fixed field widths on the streams
    localparam int FUNC_W   = 2;
    localparam int ITEM_W   = 10;
    localparam int STATUS_W = 2;
    localparam int BIDX_W   = 3;
    localparam int S_DATA_W = 16;
    localparam int M_DATA_W = 8;

    // operation codes
    localparam logic [FUNC_W-1:0] OP_INSERT = 2'd0;
    localparam logic [FUNC_W-1:0] OP_SEARCH = 2'd1;
    localparam logic [FUNC_W-1:0] OP_REMOVE = 2'd2;

    // result codes
    typedef enum logic [STATUS_W-1:0] {
        ST_DONE      = 2'd0,
        ST_NOT_FOUND = 2'd1,
        ST_FULL      = 2'd2
    } t_status;

    // controller to datapath
    typedef struct packed {
        logic    load_in;      // latch value, start the remainder unit
        logic    walk_init;    // cur <= head of bucket, prev <= null
        logic    alloc_fresh;  // take the next never-used node
        logic    pop_rd;       // read top of free stack
        logic    pop_take;     // take popped node, shrink stack
        logic    link;         // write node, link it at the head
        logic    walk_rd;      // read value and next of cur
        logic    walk_adv;     // prev <= cur, cur <= next
        logic    unlink;       // bypass cur, push it on the free stack
        logic    set_status;
        t_status status_code;
        logic    res_load;     // move result into the output register
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic mod_done;
        logic stk_empty;
        logic pool_full;
        logic cur_valid;
        logic match;
    } t_stat;

endpackage

[hw/rtl/chs_mod.sv]
// remainder of a value by the bucket count, by reciprocal multiplication
module chs_mod #(
    parameter int BUCKETS = chs_pkg::BUCKETS_DEF,
    parameter int VW      = chs_pkg::VALUE_BITS_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_start,
    input  logic [VW-1:0]              i_value,
    output logic                       o_done,
    output logic [$clog2(BUCKETS)-1:0] o_rem
);

    localparam int BW  = $clog2(BUCKETS);
    // quotient = (value * ceil(2^SH / BUCKETS)) >> SH, exact for all VW-bit values
    localparam int SH  = VW + BW;
    localparam int MW  = VW + 2;
    localparam int PRW = SH + VW;
    localparam int EW  = VW + BW;
    localparam logic [MW-1:0] RECIP = MW'(((1 << SH) + BUCKETS - 1) / BUCKETS);
    localparam logic [EW-1:0] BK    = EW'(BUCKETS);

    logic [VW-1:0] r_value;
    logic [VW-1:0] r_quot;
    logic [BW-1:0] r_rem;
    logic          r_st_mul;
    logic          r_st_sub;
    logic          r_done;

    logic [PRW-1:0] w_prod;
    logic [EW-1:0]  w_diff;

    always_comb begin
        w_prod = PRW'(r_value) * PRW'(RECIP);
        w_diff = EW'(r_value) - EW'(r_quot) * BK;
    end

    // multiply step, subtract step, then done for one cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st_mul <= 1'b0;
            r_st_sub <= 1'b0;
            r_done   <= 1'b0;
        end else begin
            r_st_mul <= i_start;
            r_st_sub <= r_st_mul;
            r_done   <= r_st_sub;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_value <= i_value;
        end
        if (r_st_mul) begin
            r_quot <= w_prod[SH +: VW];
        end
        if (r_st_sub) begin
            r_rem <= w_diff[BW-1:0];
        end
    end

    assign o_done = r_done;
    assign o_rem  = r_rem;

endmodule

[hw/rtl/chs_dp.sv]
// datapath: bucket heads, node memories, free stack and result register
module chs_dp #(
    parameter int BUCKETS    = chs_pkg::BUCKETS_DEF,
    parameter int POOL_NODES = chs_pkg::POOL_NODES_DEF,
    parameter int VW         = chs_pkg::VALUE_BITS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  chs_pkg::t_cmd                 i_cmd,
    output chs_pkg::t_stat                o_st,
    input  logic [chs_pkg::ITEM_W-1:0]    i_value,
    output logic [chs_pkg::STATUS_W-1:0]  o_status,
    output logic [chs_pkg::BIDX_W-1:0]    o_bucket_index
);
    import chs_pkg::*;

    localparam int BW = $clog2(BUCKETS);
    localparam int IW = $clog2(POOL_NODES);
    localparam int CW = IW + 1;
    localparam int LW = IW + 1;   // link: valid bit on top of node index

    logic [VW-1:0] r_value;
    logic [BW-1:0] w_bucket;
    logic          w_mod_done;

    logic [LW-1:0] r_head [BUCKETS];
    logic [VW-1:0] r_node_value [POOL_NODES];
    logic [LW-1:0] r_node_next  [POOL_NODES];
    logic [IW-1:0] r_stack      [POOL_NODES];

    logic [CW-1:0] r_fresh;
    logic [CW-1:0] r_stk_cnt;
    logic [IW-1:0] r_stk_rd;
    logic [IW-1:0] r_node;
    logic [LW-1:0] r_cur;
    logic [LW-1:0] r_prev;
    logic [VW-1:0] r_rd_value;
    logic [LW-1:0] r_rd_next;
    t_status       r_status;
    t_status       r_out_status;
    logic [BIDX_W-1:0] r_out_bucket;

    logic [IW-1:0] w_cur_idx;
    logic [CW-1:0] w_stk_top;
    logic [BW+BIDX_W-1:0] w_bucket_ext;

    assign w_cur_idx    = r_cur[IW-1:0];
    assign w_stk_top    = r_stk_cnt - 1'b1;
    assign w_bucket_ext = {{BIDX_W{1'b0}}, w_bucket};

    chs_mod #(
        .BUCKETS (BUCKETS),
        .VW      (VW)
    ) u_mod (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.load_in),
        .i_value (i_value[VW-1:0]),
        .o_done  (w_mod_done),
        .o_rem   (w_bucket)
    );

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_value <= i_value[VW-1:0];
        end
    end

    // chain heads, valid bits cleared by reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < BUCKETS; i++) begin
                r_head[i] <= '0;
            end
        end else if (i_cmd.link) begin
            r_head[w_bucket] <= {1'b1, r_node};
        end else if (i_cmd.unlink && !r_prev[LW-1]) begin
            r_head[w_bucket] <= r_rd_next;
        end
    end

    // node memories
    always_ff @(posedge i_clk) begin
        if (i_cmd.link) begin
            r_node_value[r_node] <= r_value;
        end
        if (i_cmd.walk_rd) begin
            r_rd_value <= r_node_value[w_cur_idx];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.link) begin
            r_node_next[r_node] <= r_head[w_bucket];
        end else if (i_cmd.unlink && r_prev[LW-1]) begin
            r_node_next[r_prev[IW-1:0]] <= r_rd_next;
        end
        if (i_cmd.walk_rd) begin
            r_rd_next <= r_node_next[w_cur_idx];
        end
    end

    // free stack of returned nodes
    always_ff @(posedge i_clk) begin
        if (i_cmd.unlink) begin
            r_stack[r_stk_cnt[IW-1:0]] <= w_cur_idx;
        end
        if (i_cmd.pop_rd) begin
            r_stk_rd <= r_stack[w_stk_top[IW-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fresh   <= '0;
            r_stk_cnt <= '0;
            r_cur     <= '0;
            r_prev    <= '0;
        end else begin
            if (i_cmd.alloc_fresh) begin
                r_fresh <= r_fresh + 1'b1;
            end
            if (i_cmd.pop_take) begin
                r_stk_cnt <= w_stk_top;
            end else if (i_cmd.unlink) begin
                r_stk_cnt <= r_stk_cnt + 1'b1;
            end
            if (i_cmd.walk_init) begin
                r_cur  <= r_head[w_bucket];
                r_prev <= '0;
            end else if (i_cmd.walk_adv) begin
                r_prev <= r_cur;
                r_cur  <= r_rd_next;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.alloc_fresh) begin
            r_node <= r_fresh[IW-1:0];
        end else if (i_cmd.pop_take) begin
            r_node <= r_stk_rd;
        end
        if (i_cmd.set_status) begin
            r_status <= i_cmd.status_code;
        end
        if (i_cmd.res_load) begin
            r_out_status <= r_status;
            r_out_bucket <= w_bucket_ext[BIDX_W-1:0];
        end
    end

    always_comb begin
        o_st.mod_done  = w_mod_done;
        o_st.stk_empty = (r_stk_cnt == '0);
        o_st.pool_full = (r_fresh == CW'(POOL_NODES));
        o_st.cur_valid = r_cur[LW-1];
        o_st.match     = (r_rd_value == r_value);
    end

    assign o_status       = r_out_status;
    assign o_bucket_index = r_out_bucket;

endmodule

[hw/rtl/chs_ctrl.sv]
// controller state machine of the chained hash set
module chs_ctrl (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_s_tvalid,
    output logic                       o_s_tready,
    input  logic [chs_pkg::FUNC_W-1:0] i_func,
    output logic                       o_m_tvalid,
    input  logic                       i_m_tready,
    input  chs_pkg::t_stat             i_st,
    output chs_pkg::t_cmd              o_cmd
);
    import chs_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_HASH,
        S_ALLOC,
        S_POP,
        S_LINK,
        S_WCHK,
        S_WCMP,
        S_RES
    } t_state;

    t_state            r_state, n_state;
    logic [FUNC_W-1:0] r_op;
    logic              r_m_tvalid;
    t_cmd              w_cmd;

    always_comb begin
        n_state = r_state;
        w_cmd   = '0;
        w_cmd.status_code = ST_NOT_FOUND;
        case (r_state)
            S_IDLE: begin
                if (i_s_tvalid) begin
                    w_cmd.load_in = 1'b1;
                    n_state = S_HASH;
                end
            end
            S_HASH: begin
                if (i_st.mod_done) begin
                    case (r_op)
                        OP_INSERT: begin
                            n_state = S_ALLOC;
                        end
                        OP_SEARCH, OP_REMOVE: begin
                            w_cmd.walk_init = 1'b1;
                            n_state = S_WCHK;
                        end
                        default: begin
                            w_cmd.set_status  = 1'b1;
                            w_cmd.status_code = ST_NOT_FOUND;
                            n_state = S_RES;
                        end
                    endcase
                end
            end
            S_ALLOC: begin
                if (!i_st.stk_empty) begin
                    w_cmd.pop_rd = 1'b1;
                    n_state = S_POP;
                end else if (!i_st.pool_full) begin
                    w_cmd.alloc_fresh = 1'b1;
                    n_state = S_LINK;
                end else begin
                    w_cmd.set_status  = 1'b1;
                    w_cmd.status_code = ST_FULL;
                    n_state = S_RES;
                end
            end
            S_POP: begin
                w_cmd.pop_take = 1'b1;
                n_state = S_LINK;
            end
            S_LINK: begin
                w_cmd.link        = 1'b1;
                w_cmd.set_status  = 1'b1;
                w_cmd.status_code = ST_DONE;
                n_state = S_RES;
            end
            S_WCHK: begin
                if (i_st.cur_valid) begin
                    w_cmd.walk_rd = 1'b1;
                    n_state = S_WCMP;
                end else begin
                    w_cmd.set_status  = 1'b1;
                    w_cmd.status_code = ST_NOT_FOUND;
                    n_state = S_RES;
                end
            end
            S_WCMP: begin
                if (i_st.match) begin
                    w_cmd.set_status  = 1'b1;
                    w_cmd.status_code = ST_DONE;
                    w_cmd.unlink      = (r_op == OP_REMOVE);
                    n_state = S_RES;
                end else begin
                    w_cmd.walk_adv = 1'b1;
                    n_state = S_WCHK;
                end
            end
            S_RES: begin
                if (!r_m_tvalid || i_m_tready) begin
                    w_cmd.res_load = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_op       <= OP_INSERT;
            r_m_tvalid <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_m_tvalid <= (r_m_tvalid && !i_m_tready) || w_cmd.res_load;
            if (w_cmd.load_in) begin
                r_op <= i_func;
            end
        end
    end

    assign o_s_tready = (r_state == S_IDLE);
    assign o_m_tvalid = r_m_tvalid;
    assign o_cmd      = w_cmd;

endmodule

[hw/rtl/chained_hash_set.sv]
// top level of the chained hash set: controller, datapath and assertions
//
// Keeps a set of values in BUCKETS chains picked by value mod BUCKETS, with
// nodes drawn from a pool of POOL_NODES. One item is worked at a time; the
// next item is taken as soon as the previous result sits in the output
// register, even if the sink has not yet taken it. Every item first goes
// through the remainder unit, a reciprocal multiply and a subtract in two
// registered steps. After that an insert takes a node, reusing a removed
// node from the free stack if there is one, links it and hands over the
// result; a search or remove walks the chain, each hop being one registered
// read of the node memories, and then hands over a hit or closes a miss.
// A full output register holds the item until the sink takes the older
// result. The pool starts empty with no clearing pass: never-used nodes are
// handed out from a fill count, and removed nodes return on a free stack.
// Duplicates get nodes of their own and the newest copy, nearest the chain
// head, is the one found or removed.
module chained_hash_set #(
    parameter int BUCKETS    = chs_pkg::BUCKETS_DEF,
    parameter int POOL_NODES = chs_pkg::POOL_NODES_DEF,
    parameter int VALUE_BITS = chs_pkg::VALUE_BITS_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    // input items
    input  logic                         i_s_tvalid,
    output logic                         o_s_tready,
    input  logic [chs_pkg::S_DATA_W-1:0] i_s_tdata,   // [9:0] item_value, rest zero
    input  logic [chs_pkg::FUNC_W-1:0]   i_s_tuser,   // [1:0] func
    // result items
    output logic                         o_m_tvalid,
    input  logic                         i_m_tready,
    output logic [chs_pkg::M_DATA_W-1:0] o_m_tdata,   // [2:0] bucket_index, rest zero
    output logic [chs_pkg::STATUS_W-1:0] o_m_tuser    // [1:0] status
);
    import chs_pkg::*;

    // only the low bits of the value field take part
    localparam int VW = (VALUE_BITS < ITEM_W) ? VALUE_BITS : ITEM_W;

    t_cmd  w_cmd;
    t_stat w_st;
    logic [BIDX_W-1:0] w_bucket_index;

    // sequencing of insert, walk and unlink
    chs_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_func     (i_s_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .i_st       (w_st),
        .o_cmd      (w_cmd)
    );

    // storage: heads, node memories, free stack, result payload
    chs_dp #(
        .BUCKETS    (BUCKETS),
        .POOL_NODES (POOL_NODES),
        .VW         (VW)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (w_cmd),
        .o_st           (w_st),
        .i_value        (i_s_tdata[ITEM_W-1:0]),
        .o_status       (o_m_tuser),
        .o_bucket_index (w_bucket_index)
    );

    assign o_m_tdata = M_DATA_W'(w_bucket_index);

    // an accepted item keeps the input side closed while it is worked
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_tvalid && o_s_tready) |=> !o_s_tready)
        else $error("input taken while an item is in flight");

    // fresh nodes are only used once the free stack is drained
    a_fresh_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.alloc_fresh |-> (w_st.stk_empty && !w_st.pool_full))
        else $error("fresh node taken with free nodes on the stack");

    // pool full reported only when no node is left anywhere
    a_full_real: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_cmd.set_status && (w_cmd.status_code == ST_FULL))
            |-> (w_st.stk_empty && w_st.pool_full))
        else $error("pool full reported with free nodes");

    // unlink only on a matching node
    a_unlink_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.unlink |-> (w_st.match && w_st.cur_valid))
        else $error("unlink without a match");

    // a loaded result shows up on the output next cycle
    a_result_shown: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.res_load |=> o_m_tvalid)
        else $error("result loaded but not presented");

endmodule

[tb/chained_hash_set_test.sv]
// self-checking testbench of the chained hash set: stream drivers and result scoreboard
module chained_hash_set_test;
    import chs_pkg::*;

    localparam int BUCKETS    = BUCKETS_DEF;
    localparam int POOL_NODES = POOL_NODES_DEF;

    // operation code the block must treat as a no-op
    localparam logic [FUNC_W-1:0] OP_UNUSED = 2'd3;

    // worst case per item: hashing plus a walk over the whole pool
    localparam int DRAIN_CYCLES = 2 * POOL_NODES + 64;
    localparam int HOLD_CYCLES  = 400;
    localparam int RING_SIZE    = 32;

    // one expected result item
    typedef struct {
        t_status               status;
        logic [BIDX_W-1:0]     bucket;
    } t_hash_result;

    // mirrors the set contents and queues the result each item must produce
    class t_scoreboard;
        bit                head_ok   [BUCKETS];
        int                head_at   [BUCKETS];
        logic [ITEM_W-1:0] slot_value[POOL_NODES];
        bit                next_ok   [POOL_NODES];
        int                next_at   [POOL_NODES];
        bit                slot_busy [POOL_NODES];
        t_hash_result      pending_results[$];
        int mismatches, items_in, n_done, n_missing, n_full;

        function new();
            foreach (head_ok[i]) head_ok[i] = 1'b0;
            foreach (slot_busy[i]) begin
                slot_busy[i]  = 1'b0;
                next_ok[i]    = 1'b0;
                slot_value[i] = '0;
            end
            mismatches = 0;
            items_in   = 0;
            n_done     = 0;
            n_missing  = 0;
            n_full     = 0;
        endfunction

        // apply one accepted item to the mirrored set and queue its result
        function void note_item(logic [FUNC_W-1:0] func, logic [ITEM_W-1:0] value);
            int           b, slot, cur, prev, steps, i;
            bit           cur_ok, prev_ok, hit;
            t_status      st;
            t_hash_result r;
            b  = int'(value) % BUCKETS;
            st = ST_NOT_FOUND;
            if (func == OP_INSERT) begin
                // lowest free node; which node is taken is not visible outside
                slot = -1;
                for (i = POOL_NODES - 1; i >= 0; i--)
                    if (!slot_busy[i]) slot = i;
                if (slot < 0) begin
                    st = ST_FULL;
                end else begin
                    slot_busy[slot]  = 1'b1;
                    slot_value[slot] = value;
                    next_ok[slot]    = head_ok[b];
                    next_at[slot]    = head_at[b];
                    head_ok[b]       = 1'b1;
                    head_at[b]       = slot;
                    st = ST_DONE;
                end
            end else if (func == OP_SEARCH || func == OP_REMOVE) begin
                cur_ok  = head_ok[b];
                cur     = head_at[b];
                prev_ok = 1'b0;
                prev    = 0;
                steps   = 0;
                hit     = 1'b0;
                while (cur_ok && !hit && steps < POOL_NODES) begin
                    if (slot_value[cur] == value) begin
                        hit = 1'b1;
                        st  = ST_DONE;
                        if (func == OP_REMOVE) begin
                            if (prev_ok) begin
                                next_ok[prev] = next_ok[cur];
                                next_at[prev] = next_at[cur];
                            end else begin
                                head_ok[b] = next_ok[cur];
                                head_at[b] = next_at[cur];
                            end
                            slot_busy[cur] = 1'b0;
                            next_ok[cur]   = 1'b0;
                        end
                    end else begin
                        prev_ok = 1'b1;
                        prev    = cur;
                        cur_ok  = next_ok[cur];
                        cur     = next_at[cur];
                        steps++;
                    end
                end
            end
            r.status = st;
            r.bucket = BIDX_W'(b);
            pending_results.push_back(r);
            items_in++;
        endfunction

        // compare one accepted result with the oldest queued one
        function void check_result(logic [STATUS_W-1:0] status, logic [BIDX_W-1:0] bucket);
            t_hash_result r;
            if (pending_results.size() == 0) begin
                $error("result with no item pending: status %0d bucket_index %0d",
                       status, bucket);
                mismatches++;
                return;
            end
            r = pending_results.pop_front();
            if (status !== r.status) begin
                $error("status mismatch: expected %0d, got %0d", r.status, status);
                mismatches++;
            end
            if (bucket !== r.bucket) begin
                $error("bucket_index mismatch: expected %0d, got %0d", r.bucket, bucket);
                mismatches++;
            end
            case (r.status)
                ST_DONE:      n_done++;
                ST_NOT_FOUND: n_missing++;
                default:      n_full++;
            endcase
        endfunction
    endclass

    logic                   i_clk      = 1'b0;
    logic                   i_rst_n    = 1'b0;
    logic                   i_s_tvalid = 1'b0;
    logic                   o_s_tready;
    logic [S_DATA_W-1:0]    i_s_tdata  = '0;    // [9:0] item_value, rest zero
    logic [FUNC_W-1:0]      i_s_tuser  = '0;    // [1:0] func
    logic                   o_m_tvalid;
    logic                   i_m_tready = 1'b0;
    logic [M_DATA_W-1:0]    o_m_tdata;          // [2:0] bucket_index, rest zero
    logic [STATUS_W-1:0]    o_m_tuser;          // [1:0] status

    // idle rates of both sides in percent, and the request for the long sink stall
    int src_idle_pct = 0;
    int snk_idle_pct = 0;
    bit hold_req     = 1'b0;

    t_scoreboard board = new();

    // values inserted lately, so that searches and removes mostly hit
    logic [ITEM_W-1:0] recent_vals[RING_SIZE];
    int                recent_wr = 0;

    chained_hash_set u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // offer one item, with a random gap first, and hold it until it is taken
    // valid stays high between back-to-back items and goes low only in a random gap
    task automatic send_item(input logic [FUNC_W-1:0] func, input logic [ITEM_W-1:0] value);
        while ($urandom_range(0, 99) < src_idle_pct) begin
            i_s_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= S_DATA_W'(value);
        i_s_tuser  <= func;
        @(posedge i_clk);
        while (!o_s_tready) @(posedge i_clk);
        board.note_item(func, value);
        if (func == OP_INSERT) begin
            recent_vals[recent_wr % RING_SIZE] = value;
            recent_wr++;
        end
    endtask

    // random traffic in blocks: fill, fill, mixed, drain, so the pool runs full
    // and empties again; a share of values lands in one bucket for long chains
    task automatic run_random(input int n_items);
        int                k, r, mode, fill;
        logic [FUNC_W-1:0] func;
        logic [ITEM_W-1:0] value;
        for (k = 0; k < n_items; k++) begin
            mode = (k / 100) % 4;
            r    = $urandom_range(0, 99);
            case (mode)
                0, 1: func = (r < 70) ? OP_INSERT : (r < 88) ? OP_SEARCH :
                             (r < 98) ? OP_REMOVE : OP_UNUSED;
                2:    func = (r < 35) ? OP_INSERT : (r < 70) ? OP_SEARCH :
                             (r < 98) ? OP_REMOVE : OP_UNUSED;
                default: func = (r < 15) ? OP_INSERT : (r < 40) ? OP_SEARCH :
                                (r < 98) ? OP_REMOVE : OP_UNUSED;
            endcase
            fill = (recent_wr < RING_SIZE) ? recent_wr : RING_SIZE;
            r    = $urandom_range(0, 99);
            if (r < 55 && fill > 0)
                value = recent_vals[$urandom_range(0, fill - 1)];
            else if (r < 75)
                value = ITEM_W'($urandom_range(0, 145) * BUCKETS + 3);
            else
                value = ITEM_W'($urandom_range(0, 1023));
            send_item(func, value);
        end
    endtask

    // result side: check accepted results, random backpressure, one long stall
    initial begin : sink
        int hold_left;
        bit hold_done;
        hold_left = 0;
        hold_done = 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_m_tvalid && i_m_tready)
                board.check_result(o_m_tuser, o_m_tdata[BIDX_W-1:0]);
            if (hold_req && !hold_done) begin
                hold_left = HOLD_CYCLES;
                hold_done = 1'b1;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_m_tready <= 1'b0;
            end else begin
                i_m_tready <= ($urandom_range(0, 99) >= snk_idle_pct);
            end
        end
    end

    // stimulus and end of run
    initial begin : driver
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        src_idle_pct = 14;
        snk_idle_pct = 70;

        // directed: field extremes, duplicates, misses, the unused code
        send_item(OP_SEARCH, 10'd0);       // empty bucket
        send_item(OP_REMOVE, 10'd1023);    // remove from empty set
        send_item(OP_INSERT, 10'd0);
        send_item(OP_INSERT, 10'd1023);
        send_item(OP_SEARCH, 10'd0);
        send_item(OP_SEARCH, 10'd1023);
        send_item(OP_SEARCH, 10'd7);       // same bucket as 0, miss after a walk
        send_item(OP_INSERT, 10'd1023);    // duplicate gets its own node
        send_item(OP_REMOVE, 10'd1023);    // newest copy goes
        send_item(OP_SEARCH, 10'd1023);    // older copy still there
        send_item(OP_REMOVE, 10'd1023);
        send_item(OP_SEARCH, 10'd1023);    // now gone
        send_item(OP_INSERT, 10'd7);
        send_item(OP_REMOVE, 10'd0);       // unlink from the tail of a chain
        send_item(OP_SEARCH, 10'd7);
        send_item(OP_UNUSED, 10'd5);       // no-op, still answers
        send_item(OP_UNUSED, 10'd1023);
        send_item(OP_INSERT, 10'h155);
        send_item(OP_INSERT, 10'h2AA);
        send_item(OP_SEARCH, 10'h155);
        send_item(OP_REMOVE, 10'h2AA);

        run_random(410);

        src_idle_pct = 70;
        snk_idle_pct = 14;
        run_random(410);

        // no idling; the sink stalls for a long stretch while items keep coming
        src_idle_pct = 0;
        snk_idle_pct = 0;
        hold_req <= 1'b1;
        run_random(410);

        i_s_tvalid <= 1'b0;
        while (board.pending_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("tb: %0d items, %0d mismatches", board.items_in, board.mismatches);
        $display("tb: results done/found %0d, not found %0d, pool full %0d",
                 board.n_done, board.n_missing, board.n_full);
        if (board.mismatches == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

    // watchdog, far beyond the slowest legal run
    initial begin : watchdog
        #30_000_000;
        $display("tb: failure");
        $finish;
    end

endmodule
